>>> hw/rtl/wsol_pkg.sv
package wsol_pkg;

  localparam int LIST_DEPTH  = 32;
  localparam int HANDLE_BITS = 8;
  localparam int IDX_W       = $clog2(LIST_DEPTH);
  localparam int CNT_W       = $clog2(LIST_DEPTH + 1);
  localparam int KEPT_W      = $clog2(LIST_DEPTH + 2);

  localparam int CMD_W      = 2;
  localparam int HANDLE_W   = 8;
  localparam int RIDX_W     = 5;
  localparam int ECOUNT_W   = 6;

  typedef enum logic [CMD_W-1:0] {
    CMD_REMOVE = 2'd0,
    CMD_FRONT  = 2'd1,
    CMD_BACK   = 2'd2,
    CMD_QUERY  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_COMMIT,
    S_RD_FRONT,
    S_RD_ENTRY,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic                   we;
    logic [IDX_W-1:0]       waddr;
    logic [HANDLE_BITS-1:0] wdata;
    logic [IDX_W-1:0]       raddr;
  } ram_req_t;

endpackage

>>> hw/rtl/wsol_if.sv
interface wsol_in_if;
  import wsol_pkg::*;

  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    command;
  logic [HANDLE_W-1:0] handle;
  logic [RIDX_W-1:0]   read_index;

  modport source (output valid, command, handle, read_index, input ready);
  modport sink   (input valid, command, handle, read_index, output ready);
endinterface

interface wsol_out_if;
  import wsol_pkg::*;

  logic                valid;
  logic                ready;
  logic [ECOUNT_W-1:0] entry_count;
  logic [HANDLE_W-1:0] front_handle;
  logic [HANDLE_W-1:0] entry_value;
  logic                entry_valid;
  logic                was_present;

  modport source (output valid, entry_count, front_handle, entry_value, entry_valid,
                  was_present, input ready);
  modport sink   (input valid, entry_count, front_handle, entry_value, entry_valid,
                  was_present, output ready);
endinterface

>>> hw/rtl/window_stacking_order_list.sv
// Window stacking order list: an ordered list of window handles, front first.
// in_chan (valid/ready) carries one command transaction: command, handle and
// read_index. Commands remove a handle, bring it to the front, send it to the
// back, or only query. out_chan (valid/ready) returns one transaction per
// command: entry count, front handle, entry at read_index with its valid
// mark, and whether the handle was present before the update.
// The list lives in two ping-pong RAM banks; one sequencer walks the active
// bank one entry per cycle, comparing against the handle and copying the
// survivors into the other bank, then flips banks unless the command is a
// query or an insert that finds the list full. The walk reads every entry, so
// the time from accept to out valid and to the next accept grows with the
// entry count before the update.
// in_chan.ready is high only while idle, so one command is in flight at a
// time. The result sits in an output register; while the receiver stalls it
// holds, and the next command may be accepted, finishing its walk and then
// waiting until the held result is taken.
// Synchronous active-low reset empties the list and drops any pending
// result; RAM contents are not cleared.
module window_stacking_order_list (
  input  logic       clk,
  input  logic       rst_n,
  wsol_in_if.sink    in_chan,
  wsol_out_if.source out_chan
);
  import wsol_pkg::*;

  ram_req_t               ram0_req;
  ram_req_t               ram1_req;
  logic [HANDLE_BITS-1:0] ram0_rdata;
  logic [HANDLE_BITS-1:0] ram1_rdata;

  wsol_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .out_chan   (out_chan),
    .ram0_req   (ram0_req),
    .ram1_req   (ram1_req),
    .ram0_rdata (ram0_rdata),
    .ram1_rdata (ram1_rdata)
  );

  wsol_ram #(
    .WIDTH (HANDLE_BITS),
    .DEPTH (LIST_DEPTH)
  ) u_bank0 (
    .clk   (clk),
    .we    (ram0_req.we),
    .waddr (ram0_req.waddr),
    .wdata (ram0_req.wdata),
    .raddr (ram0_req.raddr),
    .rdata (ram0_rdata)
  );

  wsol_ram #(
    .WIDTH (HANDLE_BITS),
    .DEPTH (LIST_DEPTH)
  ) u_bank1 (
    .clk   (clk),
    .we    (ram1_req.we),
    .waddr (ram1_req.waddr),
    .wdata (ram1_req.wdata),
    .raddr (ram1_req.raddr),
    .rdata (ram1_rdata)
  );

endmodule

>>> hw/rtl/wsol_ram.sv
module wsol_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/wsol_ctrl.sv
module wsol_ctrl (
  input  logic                             clk,
  input  logic                             rst_n,
  wsol_in_if.sink                          in_chan,
  wsol_out_if.source                       out_chan,
  output wsol_pkg::ram_req_t               ram0_req,
  output wsol_pkg::ram_req_t               ram1_req,
  input  logic [wsol_pkg::HANDLE_BITS-1:0] ram0_rdata,
  input  logic [wsol_pkg::HANDLE_BITS-1:0] ram1_rdata
);
  import wsol_pkg::*;

  state_t                 state_r, state_nxt;
  logic                   bank_r, bank_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;
  cmd_t                   cmd_r, cmd_nxt;
  logic [HANDLE_BITS-1:0] h_r, h_nxt;
  logic [RIDX_W-1:0]      idx_r, idx_nxt;
  logic [CNT_W-1:0]       rd_r, rd_nxt;
  logic                   pend_r, pend_nxt;
  logic [KEPT_W-1:0]      kept_r, kept_nxt;
  logic                   present_r, present_nxt;
  logic [HANDLE_BITS-1:0] front_r, front_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [ECOUNT_W-1:0]    out_count_r, out_count_nxt;
  logic [HANDLE_W-1:0]    out_front_r, out_front_nxt;
  logic [HANDLE_W-1:0]    out_value_r, out_value_nxt;
  logic                   out_evalid_r, out_evalid_nxt;
  logic                   out_present_r, out_present_nxt;

  logic                   accept;
  logic                   rd_issue;
  logic                   walk_done;
  logic                   out_free;
  logic                   entry_ok;
  logic [HANDLE_BITS-1:0] src_data;
  ram_req_t               req;

  assign in_chan.ready = (state_r == S_IDLE);
  assign accept        = in_chan.valid && in_chan.ready;
  assign rd_issue      = (rd_r < count_r);
  assign walk_done     = !pend_r && !rd_issue;
  assign out_free      = !out_valid_r || out_chan.ready;
  assign entry_ok      = (32'(idx_r) < 32'(count_r));
  assign src_data      = bank_r ? ram1_rdata : ram0_rdata;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:     if (accept) state_nxt = S_WALK;
      S_WALK:     if (walk_done) state_nxt = S_COMMIT;
      S_COMMIT:   state_nxt = S_RD_FRONT;
      S_RD_FRONT: state_nxt = S_RD_ENTRY;
      S_RD_ENTRY: state_nxt = S_RESULT;
      S_RESULT:   if (out_free) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    bank_nxt        = bank_r;
    count_nxt       = count_r;
    cmd_nxt         = cmd_r;
    h_nxt           = h_r;
    idx_nxt         = idx_r;
    rd_nxt          = rd_r;
    pend_nxt        = pend_r;
    kept_nxt        = kept_r;
    present_nxt     = present_r;
    front_nxt       = front_r;
    out_valid_nxt   = out_valid_r && !out_chan.ready;
    out_count_nxt   = out_count_r;
    out_front_nxt   = out_front_r;
    out_value_nxt   = out_value_r;
    out_evalid_nxt  = out_evalid_r;
    out_present_nxt = out_present_r;
    req             = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt     = cmd_t'(in_chan.command);
          h_nxt       = HANDLE_BITS'(in_chan.handle);
          idx_nxt     = in_chan.read_index;
          rd_nxt      = '0;
          pend_nxt    = 1'b0;
          present_nxt = 1'b0;
          kept_nxt    = '0;
          // front insert lands at slot zero of the other bank
          if (cmd_t'(in_chan.command) == CMD_FRONT) begin
            kept_nxt  = KEPT_W'(1);
            req.we    = 1'b1;
            req.waddr = '0;
            req.wdata = HANDLE_BITS'(in_chan.handle);
          end
        end
      end
      S_WALK: begin
        req.raddr = IDX_W'(rd_r);
        pend_nxt  = rd_issue;
        if (rd_issue) begin
          rd_nxt = rd_r + CNT_W'(1);
        end
        if (pend_r) begin
          if (src_data == h_r) begin
            present_nxt = 1'b1;
          end else begin
            kept_nxt = kept_r + KEPT_W'(1);
            if (cmd_r != CMD_QUERY && kept_r < KEPT_W'(LIST_DEPTH)) begin
              req.we    = 1'b1;
              req.waddr = IDX_W'(kept_r);
              req.wdata = src_data;
            end
          end
        end
      end
      S_COMMIT: begin
        case (cmd_r)
          CMD_REMOVE: begin
            count_nxt = CNT_W'(kept_r);
            bank_nxt  = !bank_r;
          end
          CMD_FRONT: begin
            if (kept_r <= KEPT_W'(LIST_DEPTH)) begin
              count_nxt = CNT_W'(kept_r);
              bank_nxt  = !bank_r;
            end
          end
          CMD_BACK: begin
            if (kept_r < KEPT_W'(LIST_DEPTH)) begin
              req.we    = 1'b1;
              req.waddr = IDX_W'(kept_r);
              req.wdata = h_r;
              count_nxt = CNT_W'(kept_r + KEPT_W'(1));
              bank_nxt  = !bank_r;
            end
          end
          default: begin
          end
        endcase
      end
      S_RD_FRONT: begin
        req.raddr = '0;
      end
      S_RD_ENTRY: begin
        req.raddr = IDX_W'(idx_r);
        front_nxt = src_data;
      end
      S_RESULT: begin
        req.raddr = IDX_W'(idx_r);
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_count_nxt   = ECOUNT_W'(count_r);
          out_front_nxt   = (count_r != '0) ? HANDLE_W'(front_r) : '0;
          out_value_nxt   = entry_ok ? HANDLE_W'(src_data) : '0;
          out_evalid_nxt  = entry_ok;
          out_present_nxt = present_r;
        end
      end
      default: begin
      end
    endcase
  end

  // reads go to both banks, writes only to the bank not in use
  always_comb begin
    ram0_req       = req;
    ram1_req       = req;
    ram0_req.we    = req.we && bank_r;
    ram1_req.we    = req.we && !bank_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      bank_r      <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bank_r      <= bank_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r         <= cmd_nxt;
    h_r           <= h_nxt;
    idx_r         <= idx_nxt;
    rd_r          <= rd_nxt;
    pend_r        <= pend_nxt;
    kept_r        <= kept_nxt;
    present_r     <= present_nxt;
    front_r       <= front_nxt;
    out_count_r   <= out_count_nxt;
    out_front_r   <= out_front_nxt;
    out_value_r   <= out_value_nxt;
    out_evalid_r  <= out_evalid_nxt;
    out_present_r <= out_present_nxt;
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.entry_count  = out_count_r;
  assign out_chan.front_handle = out_front_r;
  assign out_chan.entry_value  = out_value_r;
  assign out_chan.entry_valid  = out_evalid_r;
  assign out_chan.was_present  = out_present_r;

endmodule

>>> verif/tb_window_stacking_order_list.sv
`timescale 1ns / 100ps

module tb_window_stacking_order_list;
  import wsol_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_ITEMS = 1130;
  localparam int DRAIN_CYCLES = 60;
  localparam int MAX_PRINTS = 40;

  typedef struct {
    cmd_t                cmd;
    logic [HANDLE_W-1:0] handle;
    logic [RIDX_W-1:0]   read_index;
  } window_cmd_t;

  typedef struct {
    logic [ECOUNT_W-1:0] entry_count;
    logic [HANDLE_W-1:0] front_handle;
    logic [HANDLE_W-1:0] entry_value;
    logic                entry_valid;
    logic                was_present;
  } list_view_t;

  logic clk;
  logic rst_n;

  wsol_in_if  in_chan ();
  wsol_out_if out_chan ();

  window_stacking_order_list dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  window_cmd_t               command_queue[$];
  list_view_t                predicted_views[$];
  logic [HANDLE_BITS-1:0]    window_order[$];
  int                        err_count;
  int                        cycle_count;
  int                        gap_left;
  int                        burst_left;
  int                        rx_mode;
  int                        rx_left;

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic report_mismatch(string field, int unsigned got, int unsigned want);
    if (err_count < MAX_PRINTS)
      $display("%0t mismatch on %s: got %0h, expected %0h", $time, field, got, want);
    err_count++;
  endtask

  function automatic list_view_t apply_command(window_cmd_t c);
    logic [HANDLE_BITS-1:0] key;
    logic [HANDLE_BITS-1:0] kept[$];
    list_view_t             v;
    bit                     found;
    key   = c.handle[HANDLE_BITS-1:0];
    found = 1'b0;
    foreach (window_order[i])
      if (window_order[i] == key) found = 1'b1;
    if (c.cmd != CMD_QUERY) begin
      foreach (window_order[i])
        if (window_order[i] != key) kept.push_back(window_order[i]);
      // insert is dropped when the list is still full
      if (c.cmd != CMD_REMOVE && kept.size() < LIST_DEPTH) begin
        if (c.cmd == CMD_FRONT) kept.push_front(key);
        else kept.push_back(key);
      end
      window_order = kept;
    end
    v.entry_count  = ECOUNT_W'(window_order.size());
    v.front_handle = (window_order.size() > 0) ? HANDLE_W'(window_order[0]) : '0;
    v.entry_valid  = c.read_index < window_order.size();
    v.entry_value  = v.entry_valid ? HANDLE_W'(window_order[c.read_index]) : '0;
    v.was_present  = found;
    return v;
  endfunction

  task automatic add_command(cmd_t cmd, logic [HANDLE_W-1:0] h, logic [RIDX_W-1:0] idx);
    window_cmd_t c;
    c.cmd        = cmd;
    c.handle     = h;
    c.read_index = idx;
    command_queue.push_back(c);
  endtask

  // sender: bursts with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid      <= 1'b0;
      in_chan.command    <= '0;
      in_chan.handle     <= '0;
      in_chan.read_index <= '0;
      gap_left      = 0;
      burst_left    = $urandom_range(1, 8);
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        window_cmd_t c;
        c.cmd        = cmd_t'(in_chan.command);
        c.handle     = in_chan.handle;
        c.read_index = in_chan.read_index;
        predicted_views.push_back(apply_command(c));
        void'(command_queue.pop_front());
      end
      if (!in_chan.valid || in_chan.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_chan.valid <= 1'b0;
        end else if (command_queue.size() > 0) begin
          in_chan.valid      <= 1'b1;
          in_chan.command    <= command_queue[0].cmd;
          in_chan.handle     <= command_queue[0].handle;
          in_chan.read_index <= command_queue[0].read_index;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 45);
          end
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  // receiver: open, closed and jittery stretches
  always @(posedge clk) begin
    if (rx_left <= 0) begin
      rx_mode = $urandom_range(0, 3);
      case (rx_mode)
        0, 1: rx_left = $urandom_range(20, 200);
        2: rx_left = $urandom_range(1, 60);
        default: rx_left = $urandom_range(30, 150);
      endcase
    end
    rx_left--;
    case (rx_mode)
      0, 1: out_chan.ready <= 1'b1;
      2: out_chan.ready <= 1'b0;
      default: out_chan.ready <= 1'($urandom_range(0, 1));
    endcase
  end

  // monitor: each result transaction against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (predicted_views.size() == 0) begin
        report_mismatch("unexpected transaction", 0, 0);
      end else begin
        list_view_t want;
        want = predicted_views.pop_front();
        if (out_chan.entry_count !== want.entry_count)
          report_mismatch("entry_count", out_chan.entry_count, want.entry_count);
        if (out_chan.front_handle !== want.front_handle)
          report_mismatch("front_handle", out_chan.front_handle, want.front_handle);
        if (out_chan.entry_value !== want.entry_value)
          report_mismatch("entry_value", out_chan.entry_value, want.entry_value);
        if (out_chan.entry_valid !== want.entry_valid)
          report_mismatch("entry_valid", out_chan.entry_valid, want.entry_valid);
        if (out_chan.was_present !== want.was_present)
          report_mismatch("was_present", out_chan.was_present, want.was_present);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_window_stacking_order_list failed");
      $finish;
    end
  end

  initial begin
    int     made;
    int     phase;
    int     seq_len;
    int     pool;
    int     roll;
    int     base;
    cmd_t   cmd;
    logic [HANDLE_W-1:0] h;

    // directed: empty list, extremes, moves of present handles
    add_command(CMD_QUERY,  8'h00, 5'd0);
    add_command(CMD_QUERY,  8'hff, 5'd31);
    add_command(CMD_REMOVE, 8'h00, 5'd0);
    add_command(CMD_FRONT,  8'h00, 5'd0);
    add_command(CMD_FRONT,  8'hff, 5'd1);
    add_command(CMD_BACK,   8'h80, 5'd2);
    add_command(CMD_BACK,   8'h01, 5'd3);
    add_command(CMD_QUERY,  8'h01, 5'd31);
    add_command(CMD_FRONT,  8'h80, 5'd0);
    add_command(CMD_BACK,   8'hff, 5'd3);
    add_command(CMD_FRONT,  8'h80, 5'd1);
    add_command(CMD_REMOVE, 8'h01, 5'd2);
    add_command(CMD_REMOVE, 8'h55, 5'd2);
    add_command(CMD_FRONT,  8'h7f, 5'd0);
    add_command(CMD_BACK,   8'hfe, 5'd4);
    add_command(CMD_QUERY,  8'hfe, 5'd5);
    add_command(CMD_REMOVE, 8'h00, 5'd1);
    add_command(CMD_REMOVE, 8'h7f, 5'd0);
    add_command(CMD_REMOVE, 8'h80, 5'd0);
    add_command(CMD_REMOVE, 8'hff, 5'd0);
    add_command(CMD_REMOVE, 8'hfe, 5'd0);
    add_command(CMD_BACK,   8'haa, 5'd0);
    add_command(CMD_FRONT,  8'h55, 5'd1);

    // random: fill, drain and mixed sequences over small handle pools
    made = 0;
    while (made < RANDOM_ITEMS) begin
      phase   = $urandom_range(0, 3);
      pool    = $urandom_range(4, 48);
      base    = $urandom_range(0, 255);
      seq_len = $urandom_range(20, 90);
      for (int k = 0; k < seq_len; k++) begin
        roll = $urandom_range(0, 99);
        case (phase)
          0, 1: cmd = (roll < 10) ? CMD_REMOVE : (roll < 20) ? CMD_QUERY :
                      (roll < 60) ? CMD_FRONT : CMD_BACK;
          2: cmd = (roll < 60) ? CMD_REMOVE : (roll < 75) ? CMD_QUERY :
                   (roll < 88) ? CMD_FRONT : CMD_BACK;
          default: cmd = cmd_t'($urandom_range(0, 3));
        endcase
        if ($urandom_range(0, 7) == 0) h = HANDLE_W'($urandom_range(0, 255));
        else h = HANDLE_W'(base + $urandom_range(0, pool - 1));
        add_command(cmd, h, RIDX_W'($urandom_range(0, 31)));
        made++;
      end
    end

    wait (rst_n === 1'b1);
    while (command_queue.size() > 0 || predicted_views.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("tb_window_stacking_order_list passed");
    end else begin
      $display("tb_window_stacking_order_list failed");
    end
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
  end

endmodule
